### hdl/assert_macros.svh
// Assertion helpers shared by the scheduler RTL.
// Each macro expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CSCD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CSCD_NEVER(name, cond, msg) \
  `CSCD_ASSERT(name, (!(cond)), msg)

`endif

### hdl/cscd_pkg.sv
`timescale 1ns / 1ps

package cscd_pkg;

  localparam int MAX_PENDING = 64;
  localparam int TRACK_BITS  = 16;

  localparam int TRK_W     = 16;
  localparam int DIST_W    = 18;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = $clog2(MAX_PENDING);
  localparam int CNT_W     = $clog2(MAX_PENDING + 1);

  localparam logic [CFG_W-1:0] TRACK_LIMIT = CFG_W'(1) << TRACK_BITS;
  localparam logic [CFG_W-1:0] MIN_TRACKS  = CFG_W'(2);

  localparam logic [TRK_W-1:0] START_HEAD_RST  = '0;
  localparam logic [CFG_W-1:0] TRACK_COUNT_RST = CFG_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HEAD  = 1'b0,
    CFG_TRACK_COUNT = 1'b1
  } cscd_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_RD,
    ST_EMIT_CALC,
    ST_EMIT_OUT,
    ST_WRAP_A,
    ST_WRAP_B
  } cscd_state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [TRK_W-1:0] data;
  } cscd_wr_t;

  typedef struct packed {
    logic [TRK_W-1:0]  a;
    logic [TRK_W-1:0]  b;
    logic [DIST_W-1:0] acc;
  } cscd_alu_in_t;

  typedef struct packed {
    logic              neg;
    logic [DIST_W-1:0] sum;
  } cscd_alu_out_t;

endpackage

### hdl/cscd_if.sv
`timescale 1ns / 1ps

interface cscd_req_if import cscd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TRK_W-1:0] track_number;
  logic             last_request;

  modport source (output valid, output track_number, output last_request, input ready);
  modport sink   (input valid, input track_number, input last_request, output ready);
endinterface

interface cscd_rsp_if import cscd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TRK_W-1:0]  served_track;
  logic [DIST_W-1:0] head_distance;
  logic              after_wrap;
  logic              dropped_some;
  logic              end_of_order;

  modport source (
    output valid, output served_track, output head_distance,
    output after_wrap, output dropped_some, output end_of_order,
    input ready
  );
  modport sink (
    input valid, input served_track, input head_distance,
    input after_wrap, input dropped_some, input end_of_order,
    output ready
  );
endinterface

### hdl/cscd_store.sv
`timescale 1ns / 1ps

module cscd_store import cscd_pkg::*; (
  input  logic             clk_i,
  input  cscd_wr_t         wr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [TRK_W-1:0] rdata_o
);

  logic [TRK_W-1:0] mem [MAX_PENDING];
  logic [TRK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cscd_alu.sv
`timescale 1ns / 1ps

module cscd_alu import cscd_pkg::*; (
  input  cscd_alu_in_t  alu_i,
  output cscd_alu_out_t alu_o
);

  logic [TRK_W:0] diff;

  // Sign of a - b doubles as the compare; the sum is used only when a >= b.
  assign diff      = {1'b0, alu_i.a} - {1'b0, alu_i.b};
  assign alu_o.neg = diff[TRK_W];
  assign alu_o.sum = alu_i.acc + DIST_W'(diff[TRK_W-1:0]);

endmodule

### hdl/cscan_disk_request_scheduler_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel | Dir | Beat contents
// req_i   | in  | track_number[15:0], last_request
// rsp_o   | out | served_track[15:0], head_distance[17:0], after_wrap,
//         |     | dropped_some, end_of_order
// cfg     | in  | cfg_we_i, cfg_idx_i (0 start_head, 1 track_count), cfg_data_i[16:0]
//
// Load: a request beat is taken in idle and put straight into an empty store, else
//   each entry it moves past takes a read and a compare, plus the compare that stops
//   it (or a put into slot 0). After the last beat: a read and a compare per entry for
//   the split (each entry below the start head and the first one at or above it), then
//   a read, a calculation and an output step per result, plus the wrap states for the
//   jump to track zero. Reset clears counters, flags and configuration, not the store.
// req_i.ready is high only in the idle state; a result waits in the output
//   register while rsp_o.ready is low and the sequencer holds.
module cscan_disk_request_scheduler_core import cscd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cscd_req_if.sink             req_i,
  cscd_rsp_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [TRK_W-1:0] start_head_q;
  logic [CFG_W-1:0] track_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q  <= START_HEAD_RST;
      track_count_q <= TRACK_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cscd_cfg_e'(cfg_idx_i))
        CFG_START_HEAD:  start_head_q  <= cfg_data_i[TRK_W-1:0];
        CFG_TRACK_COUNT: track_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Last track: count limited to [2, 2^TRACK_BITS], minus one.
  logic [CFG_W-1:0] tc_lim;
  logic [CFG_W-1:0] top_wide;
  logic [TRK_W-1:0] top;
  logic [TRK_W-1:0] trk_clamp;
  logic [TRK_W-1:0] head_clamp;

  always_comb begin
    priority if (track_count_q < MIN_TRACKS) begin
      tc_lim = MIN_TRACKS;
    end else if (track_count_q > TRACK_LIMIT) begin
      tc_lim = TRACK_LIMIT;
    end else begin
      tc_lim = track_count_q;
    end
  end

  assign top_wide   = tc_lim - CFG_W'(1);
  assign top        = top_wide[TRK_W-1:0];
  assign trk_clamp  = (req_i.track_number > top) ? top : req_i.track_number;
  assign head_clamp = (start_head_q > top) ? top : start_head_q;

  // Sequencer state and datapath registers.
  cscd_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [TRK_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  first_q, first_d;
  logic              phase_q, phase_d;
  logic [TRK_W-1:0]  cur_q, cur_d;
  logic [DIST_W-1:0] dist_q, dist_d;

  logic              out_valid_q, out_valid_d;
  logic [TRK_W-1:0]  out_track_q, out_track_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic              out_wrap_q, out_wrap_d;
  logic              out_drop_q, out_drop_d;
  logic              out_end_q, out_end_d;

  logic              in_fire;
  logic              out_fire;
  logic              has_room;
  logic              is_end;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  first_m1;
  logic [CNT_W-1:0]  k_p1;

  cscd_wr_t          st_wr;
  logic [IDX_W-1:0]  st_raddr;
  logic [TRK_W-1:0]  st_rdata;
  cscd_alu_in_t      alu_in;
  cscd_alu_out_t     alu_out;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_fire = rsp_o.valid && rsp_o.ready;
  assign has_room = count_q < CNT_W'(MAX_PENDING);
  assign cnt_m1   = count_q - CNT_W'(1);
  assign first_m1 = first_q - CNT_W'(1);
  assign k_p1     = k_q + CNT_W'(1);
  assign is_end   = (!phase_q && (k_q == cnt_m1) && (first_q == '0)) ||
                    (phase_q && (k_q == first_m1));

  cscd_store u_store (
    .clk_i   (clk_i),
    .wr_i    (st_wr),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  cscd_alu u_alu (
    .alu_i (alu_in),
    .alu_o (alu_out)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_room) begin
            state_d = (count_q == '0) ? ST_INS_PUT : ST_INS_RD;
          end else begin
            state_d = req_i.last_request ? ST_SCAN_RD : ST_IDLE;
          end
        end
      end
      ST_INS_RD:  state_d = ST_INS_CMP;
      ST_INS_CMP: begin
        if (alu_out.neg) begin
          state_d = (j_q == IDX_W'(1)) ? ST_INS_PUT : ST_INS_RD;
        end else begin
          state_d = last_q ? ST_SCAN_RD : ST_IDLE;
        end
      end
      ST_INS_PUT: state_d = last_q ? ST_SCAN_RD : ST_IDLE;
      ST_SCAN_RD: state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (alu_out.neg) begin
          // Every request below the head: nothing to serve going up first.
          state_d = (k_p1 == count_q) ? ST_WRAP_A : ST_SCAN_RD;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD:   state_d = ST_EMIT_CALC;
      ST_EMIT_CALC: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_fire) begin
          priority if (out_end_q) begin
            state_d = ST_IDLE;
          end else if (!phase_q && (k_q == cnt_m1)) begin
            state_d = ST_WRAP_A;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_WRAP_A: state_d = ST_WRAP_B;
      ST_WRAP_B: state_d = ST_EMIT_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath control, store and shared unit operands.
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    key_d       = key_q;
    j_d         = j_q;
    k_d         = k_q;
    first_d     = first_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q;
    out_track_d = out_track_q;
    out_dist_d  = out_dist_q;
    out_wrap_d  = out_wrap_q;
    out_drop_d  = out_drop_q;
    out_end_d   = out_end_q;
    st_wr       = '0;
    st_raddr    = '0;
    alu_in      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          last_d = req_i.last_request;
          k_d    = '0;
          if (has_room) begin
            key_d   = trk_clamp;
            j_d     = count_q[IDX_W-1:0];
            count_d = k_p1 - k_q + count_q;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_INS_RD: begin
        st_raddr = j_q - IDX_W'(1);
      end
      ST_INS_CMP: begin
        // Shift the larger neighbor up one slot, or drop the key in place.
        alu_in.a    = key_q;
        alu_in.b    = st_rdata;
        st_wr.we    = 1'b1;
        st_wr.addr  = j_q;
        if (alu_out.neg) begin
          st_wr.data = st_rdata;
          j_d        = j_q - IDX_W'(1);
        end else begin
          st_wr.data = key_q;
        end
      end
      ST_INS_PUT: begin
        st_wr.we   = 1'b1;
        st_wr.addr = j_q;
        st_wr.data = key_q;
      end
      ST_SCAN_RD: begin
        st_raddr = k_q[IDX_W-1:0];
        cur_d    = head_clamp;
        dist_d   = '0;
      end
      ST_SCAN_CMP: begin
        alu_in.a = st_rdata;
        alu_in.b = cur_q;
        phase_d  = 1'b0;
        if (alu_out.neg) begin
          k_d     = k_p1;
          first_d = k_p1;
        end else begin
          first_d = k_q;
        end
      end
      ST_EMIT_RD: begin
        st_raddr = k_q[IDX_W-1:0];
      end
      ST_EMIT_CALC: begin
        alu_in.a    = st_rdata;
        alu_in.b    = cur_q;
        alu_in.acc  = dist_q;
        dist_d      = alu_out.sum;
        cur_d       = st_rdata;
        out_valid_d = 1'b1;
        out_track_d = st_rdata;
        out_dist_d  = alu_out.sum;
        out_wrap_d  = phase_q;
        out_drop_d  = ovf_q;
        out_end_d   = is_end;
      end
      ST_EMIT_OUT: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (out_end_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            k_d = k_p1;
          end
        end
      end
      ST_WRAP_A: begin
        // Run from the current track up to the last track.
        alu_in.a   = top;
        alu_in.b   = cur_q;
        alu_in.acc = dist_q;
        dist_d     = alu_out.sum;
        cur_d      = '0;
      end
      ST_WRAP_B: begin
        // Jump back to track zero counts as the whole span.
        alu_in.a   = top;
        alu_in.b   = cur_q;
        alu_in.acc = dist_q;
        dist_d     = alu_out.sum;
        k_d        = '0;
        phase_d    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      first_q     <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      j_q         <= j_d;
      k_q         <= k_d;
      first_q     <= first_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    cur_q       <= cur_d;
    dist_q      <= dist_d;
    out_track_q <= out_track_d;
    out_dist_q  <= out_dist_d;
    out_wrap_q  <= out_wrap_d;
    out_drop_q  <= out_drop_d;
    out_end_q   <= out_end_d;
  end

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.served_track  = out_track_q;
  assign rsp_o.head_distance = out_dist_q;
  assign rsp_o.after_wrap    = out_wrap_q;
  assign rsp_o.dropped_some  = out_drop_q;
  assign rsp_o.end_of_order  = out_end_q;

  `CSCD_NEVER(a_ready_while_result, (req_i.ready && out_valid_q), "request taken with result pending")
  `CSCD_ASSERT(a_count_bound, (count_q <= CNT_W'(MAX_PENDING)), "request count beyond capacity")
  `CSCD_ASSERT(a_result_state, (out_valid_q |-> (state_q == ST_EMIT_OUT)), "result outside emit")
  `CSCD_ASSERT(a_wrap_needs_low, (phase_q && out_valid_q |-> (first_q != '0)), "wrap with no low requests")
  `CSCD_ASSERT(a_batch_clear, (out_fire && out_end_q |=> (count_q == '0) && !ovf_q), "batch not cleared")

endmodule
